[hw/rtl/stream_duplicate_filter_core_defines.svh]
// Assertion macros shared by the duplicate filter checker.
`ifndef STREAM_DUPLICATE_FILTER_CORE_DEFINES_SVH
`define STREAM_DUPLICATE_FILTER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sdf_pkg.sv]
// Types, sizes and helpers for the stream duplicate filter.
`default_nettype none
package sdf_pkg;

    localparam int SET_SIZE    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int ADDR_W      = $clog2(SET_SIZE);
    localparam int CNT_W       = $clog2(SET_SIZE + 1);

    typedef logic [VALUE_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic                      last;
    } in_beat_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_value;
        logic                      keep;
        logic                      out_last;
        logic                      overflow;
    } out_beat_t;

    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        key_t  wr_data;
    } ram_req_t;

    // Match key: low VALUE_WIDTH bits of the field, zero-extended if wider.
    function automatic key_t key_of(input logic [FIELD_W-1:0] raw);
        key_t k;
        k = '0;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            if (i < FIELD_W)
            begin
                k[i] = raw[i];
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sdf_ram.sv]
// Seen-value store: one write port, one registered read port.
`default_nettype none
module sdf_ram (
    input  wire logic              clk,
    input  wire sdf_pkg::ram_req_t req,
    output      sdf_pkg::key_t     rd_data
);

    sdf_pkg::key_t mem [sdf_pkg::SET_SIZE];
    sdf_pkg::key_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[hw/rtl/sdf_engine.sv]
// Lookup sequencer: scans the seen set in memory, then records or drops the value.
`default_nettype none
module sdf_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output      logic               item_stall,
    input  wire sdf_pkg::in_beat_t  item,
    input  wire logic               load_ok,
    output      logic               res_load,
    output      sdf_pkg::out_beat_t res,
    output      sdf_pkg::ram_req_t  ram_req,
    input  wire sdf_pkg::key_t      rd_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    localparam sdf_pkg::cnt_t SET_FULL = sdf_pkg::CNT_W'(sdf_pkg::SET_SIZE);

    state_t            state_reg, state_next;
    sdf_pkg::in_beat_t beat_reg, beat_next;
    sdf_pkg::cnt_t     count_reg, count_next;
    sdf_pkg::cnt_t     idx_reg, idx_next;
    logic              rvalid_reg, rvalid_next;
    logic              hit_reg, hit_next;

    sdf_pkg::key_t key;
    logic          more;
    logic          hit_found;
    logic          set_full;
    logic          issue;

    assign key       = sdf_pkg::key_of(beat_reg.value);
    assign more      = (idx_reg < count_reg);
    assign hit_found = rvalid_reg && (rd_data == key);
    assign set_full  = (count_reg == SET_FULL);
    assign issue     = (state_reg == S_SCAN) && more && !hit_found;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        beat_next   = beat_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rvalid_next = 1'b0;
        hit_next    = hit_reg;
        res_load    = 1'b0;

        ram_req.rd_en   = issue;
        ram_req.rd_addr = idx_reg[sdf_pkg::ADDR_W-1:0];
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = count_reg[sdf_pkg::ADDR_W-1:0];
        ram_req.wr_data = key;

        res.out_value = beat_reg.value;
        res.keep      = !hit_reg;
        res.out_last  = beat_reg.last;
        res.overflow  = !hit_reg && set_full;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    beat_next  = item;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle, compare lags by the RAM latency
                rvalid_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (hit_found)
                begin
                    hit_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (!more && !rvalid_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (load_ok)
                begin
                    res_load      = 1'b1;
                    ram_req.wr_en = !hit_reg && !set_full;
                    if (beat_reg.last)
                    begin
                        count_next = '0;
                    end
                    else if (!hit_reg && !set_full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
    end

endmodule
`default_nettype wire

[hw/rtl/stream_duplicate_filter_core.sv]
// Sequence: accept in idle, then the scan state compares against the n values recorded in
// this list (stopping on a match), then finish loads the result beat into the output register.
// Throughput: one item at a time, no new item is taken until finish loads the result; the scan
// reads one stored value per cycle from the single read port of the seen-value RAM.
// Reset: async active low; clears FSM, set count and output valid; the value
// RAM is not cleared, entries at or above the count are never read.
`default_nettype none
module stream_duplicate_filter_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output      logic               item_stall,
    input  wire sdf_pkg::in_beat_t  item,
    output      logic               result_valid,
    input  wire logic               result_stall,
    output      sdf_pkg::out_beat_t result
);

    sdf_pkg::ram_req_t  ram_req;
    sdf_pkg::key_t      rd_data;
    sdf_pkg::out_beat_t res;
    logic               res_load;
    logic               load_ok;

    logic               out_valid_reg, out_valid_next;
    sdf_pkg::out_beat_t out_beat_reg, out_beat_next;

    sdf_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    sdf_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .load_ok    (load_ok),
        .res_load   (res_load),
        .res        (res),
        .ram_req    (ram_req),
        .rd_data    (rd_data)
    );

    assign load_ok = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_beat_next  = res;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_beat_reg;

endmodule
`default_nettype wire

[hw/rtl/sdf_checker.sv]
// Port-level checks for the duplicate filter, bound to the top level.
`default_nettype none
`include "stream_duplicate_filter_core_defines.svh"
module sdf_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire sdf_pkg::in_beat_t  item,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire sdf_pkg::out_beat_t result
);

    `SDF_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid, "result beat dropped while stalled")
    `SDF_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(result), "stalled result beat changed")
    `SDF_ASSERT(a_dup_no_ovf, !(result_valid && !result.keep && result.overflow), "overflow flagged on a duplicate")
    `SDF_ASSERT_NEXT(a_one_item, item_valid && !item_stall, item_stall, "second beat taken during a lookup")

endmodule

bind stream_duplicate_filter_core sdf_checker u_sdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

[verif/tb_stream_duplicate_filter_core.sv]
// Self-checking testbench for stream_duplicate_filter_core with a scoreboard class.
`timescale 1ns / 1ps
module tb_stream_duplicate_filter_core;

    typedef logic signed [sdf_pkg::FIELD_W-1:0] elem_t;

    localparam int unsigned N_ITEMS      = 1500;
    localparam int unsigned LIMIT_CYCLES = 2000000;
    localparam int unsigned DRAIN_CYCLES = sdf_pkg::SET_SIZE + 16;
    localparam int unsigned MAX_WAIT     = 14;

    // Tracks the seen set of the current list and queues the beats the block must return.
    class dup_filter_predictor;
        sdf_pkg::key_t      seen_keys[sdf_pkg::SET_SIZE];
        int unsigned        seen_total;
        sdf_pkg::out_beat_t expected_beats[$];
        int unsigned        errors;

        function void note_item(sdf_pkg::in_beat_t beat);
            sdf_pkg::key_t      key;
            sdf_pkg::out_beat_t exp_beat;
            bit                 found;
            key = sdf_pkg::key_t'($unsigned(beat.value));
            found = 1'b0;
            for (int unsigned i = 0; i < seen_total; i++)
            begin
                if (seen_keys[i] == key)
                begin
                    found = 1'b1;
                end
            end
            exp_beat.out_value = beat.value;
            exp_beat.keep      = !found;
            exp_beat.out_last  = beat.last;
            exp_beat.overflow  = 1'b0;
            if (!found)
            begin
                if (seen_total < sdf_pkg::SET_SIZE)
                begin
                    seen_keys[seen_total] = key;
                    seen_total++;
                end
                else
                begin
                    // set full: passed on but not recorded
                    exp_beat.overflow = 1'b1;
                end
            end
            if (beat.last)
            begin
                seen_total = 0;
            end
            expected_beats.insert(expected_beats.size(), exp_beat);
        endfunction

        function void report(string field, longint exp_val, longint got_val, bit bad);
            if (bad)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val,
                         got_val);
                errors++;
            end
        endfunction

        function void check_result(sdf_pkg::out_beat_t got);
            sdf_pkg::out_beat_t exp_beat;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got value %0d keep %0b",
                         $time, got.out_value, got.keep);
                errors++;
            end
            else
            begin
                exp_beat = expected_beats.pop_front();
                report("out_value", longint'(exp_beat.out_value), longint'(got.out_value),
                       got.out_value !== exp_beat.out_value);
                report("keep", longint'(exp_beat.keep), longint'(got.keep),
                       got.keep !== exp_beat.keep);
                report("out_last", longint'(exp_beat.out_last), longint'(got.out_last),
                       got.out_last !== exp_beat.out_last);
                report("overflow", longint'(exp_beat.overflow), longint'(got.overflow),
                       got.overflow !== exp_beat.overflow);
            end
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    sdf_pkg::in_beat_t  item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    sdf_pkg::out_beat_t result;

    dup_filter_predictor sb;
    int unsigned         items_sent = 0;
    int unsigned         cycle_count = 0;
    int unsigned         rx_wait = 0;
    bit                  tx_burst = 1'b0;
    bit                  rx_burst = 1'b0;

    stream_duplicate_filter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check each accepted beat, then stall a random number of cycles.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
            rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (rx_wait > 0)
        begin
            result_stall <= 1'b1;
            rx_wait--;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Valid stays high from the previous beat unless a gap is drawn.
    task automatic send_item(input elem_t v, input logic is_last);
        int unsigned       gap;
        sdf_pkg::in_beat_t beat;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        beat.value = v;
        beat.last  = is_last;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do @(posedge clk); while (item_stall);
        sb.note_item(beat);
        items_sent++;
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic send_short_list(input int unsigned len);
        elem_t used[$];
        elem_t v;
        for (int unsigned i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = (used.size() != 0) ? used[$urandom_range(0, used.size() - 1)]
                                                   : elem_t'($urandom);
                4, 5: v = elem_t'($urandom_range(0, 7)) - 4;
                6:
                begin
                    case ($urandom_range(0, 3))
                        0: v = {1'b1, {(sdf_pkg::FIELD_W - 1){1'b0}}};
                        1: v = {1'b0, {(sdf_pkg::FIELD_W - 1){1'b1}}};
                        2: v = '0;
                        default: v = '1;
                    endcase
                end
                default: v = elem_t'($urandom);
            endcase
            used.insert(used.size(), v);
            send_item(v, i == len - 1);
        end
    endtask

    // Fills the set, then mixes overflowing new values with duplicates of recorded ones.
    task automatic send_full_list();
        elem_t       base;
        int unsigned k;
        int unsigned n_tail;
        elem_t       v;
        base = elem_t'($urandom);
        k = 0;
        while (k < sdf_pkg::SET_SIZE)
        begin
            if (k > 0 && $urandom_range(0, 4) == 0)
            begin
                send_item(base + $urandom_range(0, k - 1), 1'b0);
            end
            else
            begin
                send_item(base + k, 1'b0);
                k++;
            end
        end
        n_tail = $urandom_range(4, 12);
        for (int unsigned j = 0; j < n_tail; j++)
        begin
            case ($urandom_range(0, 2))
                0: v = base + sdf_pkg::SET_SIZE + $urandom_range(0, 2);
                1: v = base + $urandom_range(0, sdf_pkg::SET_SIZE - 1);
                default: v = elem_t'($urandom);
            endcase
            send_item(v, j == n_tail - 1);
        end
    endtask

    initial
    begin
        int unsigned n_full;
        sb = new;
        n_full = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // extremes, repeats of extremes, alternating bits, duplicate on the last beat
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(-32'sd1,         1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(-32'sd1,         1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shaaaa_aaaa, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh0000_0000, 1'b1);
        // stale entries from the cleared set must not match
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'sd5,          1'b0);
        send_item(32'sd5,          1'b0);
        send_item(32'sd5,          1'b1);
        send_item(32'shaaaa_aaaa, 1'b1);
        wait_for_results();

        while (items_sent < N_ITEMS)
        begin
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            if ((n_full == 0 && items_sent >= 200) || (n_full == 1 && items_sent >= 900))
            begin
                send_full_list();
                n_full++;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                send_short_list($urandom_range(13, 60));
            end
            else
            begin
                send_short_list($urandom_range(1, 12));
            end
            if ($urandom_range(0, 19) == 0)
            begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
